// ----- design/qsi_pkg.sv -----
// Shared types and constants of the quaternion spline interpolator.
// Used by the channel interfaces, controller, datapath and top level.
package qsi_pkg;

  localparam int unsigned COMP_W    = 18;
  localparam int unsigned FRAC_W    = 15;
  localparam int unsigned T_W       = 17;
  localparam int unsigned T_ONE     = 65536;
  localparam int unsigned CF_W      = 23;
  localparam int unsigned S_W       = 26;
  localparam int unsigned P_W       = S_W + COMP_W;
  localparam int unsigned ACC_W     = 2 * COMP_W + 2;
  localparam int unsigned DIV_STEPS = S_W / 2;
  localparam int unsigned SUB_W     = 5;
  localparam int unsigned DIV_OFFS  = 1 << 23;

  localparam int unsigned SUB_DACC  = 4;
  localparam int unsigned SUB_FLIP  = 5;
  localparam int unsigned SUB_DIV0  = 7;
  localparam int unsigned SUB_FIN   = SUB_DIV0 + DIV_STEPS;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_PUSH,
    OP_START,
    OP_DMUL,
    OP_DACC,
    OP_FLIP,
    OP_COEF,
    OP_HMUL,
    OP_HADD,
    OP_DSTEP,
    OP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] idx;
    logic [1:0] hstep;
    logic       load_out;
  } qsi_cmd_t;

  typedef logic signed [COMP_W-1:0] comp_t;

endpackage

// ----- design/qsi_in_if.sv -----
// Input channel: valid/ready handshake with one command item.
// Depends on qsi_pkg.
interface qsi_in_if;
  import qsi_pkg::*;
  logic           valid;
  logic           ready;
  logic           cmd;
  comp_t          key_w;
  comp_t          key_x;
  comp_t          key_y;
  comp_t          key_z;
  logic [T_W-1:0] interp_t;
  modport source (output valid, cmd, key_w, key_x, key_y, key_z, interp_t, input ready);
  modport sink (input valid, cmd, key_w, key_x, key_y, key_z, interp_t, output ready);
endinterface

// ----- design/qsi_out_if.sv -----
// Output channel: valid/ready handshake with one interpolated quaternion.
// Depends on qsi_pkg.
interface qsi_out_if;
  import qsi_pkg::*;
  logic  valid;
  logic  ready;
  comp_t out_w;
  comp_t out_x;
  comp_t out_y;
  comp_t out_z;
  modport source (output valid, out_w, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_w, out_x, out_y, out_z, output ready);
endinterface

// ----- design/quaternion_spline_interpolator_top.sv -----
// Push item: shifts one key into the window, no result. Evaluate item: the three
// sign-harmonize dot products on the shared multiplier, then per component the
// Horner steps and the radix-4 divide-by-three unit, then the output register is
// loaded (held off while an earlier result waits). No new item is taken until
// that load is done.
// Reset clears the key window to zero and spline_mode to Catmull-Rom.
module quaternion_spline_interpolator_top (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  qsi_in_if.sink    in_ch,
  qsi_out_if.source out_ch
);
  import qsi_pkg::*;

  qsi_cmd_t cmd;

  qsi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_cmd_i    (in_ch.cmd),
    .out_ready_i (out_ch.ready),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .cmd_o       (cmd)
  );

  qsi_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_w_i     (in_ch.key_w),
    .key_x_i     (in_ch.key_x),
    .key_y_i     (in_ch.key_y),
    .key_z_i     (in_ch.key_z),
    .interp_t_i  (in_ch.interp_t),
    .out_w_o     (out_ch.out_w),
    .out_x_o     (out_ch.out_x),
    .out_y_o     (out_ch.out_y),
    .out_z_o     (out_ch.out_z)
  );

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_START) |-> (in_ch.valid && in_ch.ready && in_ch.cmd))
    else $error("evaluate started without accepted item");

  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_PUSH) |-> (in_ch.valid && in_ch.ready && !in_ch.cmd))
    else $error("push without accepted item");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_ch.valid) |-> $past(cmd.load_out))
    else $error("result shown without load");

endmodule

// ----- design/qsi_ctrl.sv -----
// Sequencer of the interpolator: issues one datapath command per cycle.
// Depends on qsi_pkg.
module qsi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_cmd_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output qsi_pkg::qsi_cmd_t cmd_o
);
  import qsi_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_q, state_d;
  logic             ph_q, ph_d;
  logic [1:0]       idx_q, idx_d;
  logic [SUB_W-1:0] sub_q, sub_d;
  logic             oval_q, oval_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = oval_q;

  always_comb begin
    state_d        = state_q;
    ph_d           = ph_q;
    idx_d          = idx_q;
    sub_d          = sub_q;
    oval_d         = oval_q && !out_ready_i;
    cmd_o.op       = OP_NOP;
    cmd_o.idx      = idx_q;
    cmd_o.hstep    = sub_q[2:1] - 2'd1;
    cmd_o.load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i) begin
            cmd_o.op = OP_START;
            state_d  = ST_RUN;
            ph_d     = 1'b0;
            idx_d    = 2'd0;
            sub_d    = '0;
          end else begin
            cmd_o.op = OP_PUSH;
          end
        end
      end
      ST_RUN: begin
        sub_d = sub_q + SUB_W'(1);
        if (!ph_q) begin
          if (sub_q < SUB_W'(SUB_DACC)) begin
            cmd_o.op = OP_DMUL;
          end else if (sub_q == SUB_W'(SUB_DACC)) begin
            cmd_o.op = OP_DACC;
          end else begin
            cmd_o.op = OP_FLIP;
            sub_d    = '0;
            if (idx_q == 2'd2) begin
              ph_d  = 1'b1;
              idx_d = 2'd0;
            end else begin
              idx_d = idx_q + 2'd1;
            end
          end
        end else begin
          if (sub_q == '0) begin
            cmd_o.op = OP_COEF;
          end else if (sub_q < SUB_W'(SUB_DIV0)) begin
            cmd_o.op = sub_q[0] ? OP_HMUL : OP_HADD;
          end else if (sub_q < SUB_W'(SUB_FIN)) begin
            cmd_o.op = OP_DSTEP;
          end else begin
            cmd_o.op = OP_FIN;
            sub_d    = '0;
            idx_d    = idx_q + 2'd1;
            if (idx_q == 2'd3) begin
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_DONE: begin
        if (!oval_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          oval_d         = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= 1'b0;
      idx_q   <= 2'd0;
      sub_q   <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      idx_q   <= idx_d;
      sub_q   <= sub_d;
      oval_q  <= oval_d;
    end
  end

endmodule

// ----- design/qsi_dp.sv -----
// Datapath: key window, shared multiplier, dot accumulator, divide-by-three
// unit and result registers. Depends on qsi_pkg.
module qsi_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  qsi_pkg::qsi_cmd_t          cmd_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  qsi_pkg::comp_t             key_w_i,
  input  qsi_pkg::comp_t             key_x_i,
  input  qsi_pkg::comp_t             key_y_i,
  input  qsi_pkg::comp_t             key_z_i,
  input  logic [qsi_pkg::T_W-1:0]    interp_t_i,
  output qsi_pkg::comp_t             out_w_o,
  output qsi_pkg::comp_t             out_x_o,
  output qsi_pkg::comp_t             out_y_o,
  output qsi_pkg::comp_t             out_z_o
);
  import qsi_pkg::*;

  localparam comp_t CMAX = comp_t'((1 << (COMP_W - 1)) - 1);
  localparam comp_t CMIN = comp_t'(1 << (COMP_W - 1));

  function automatic comp_t neg_sat(comp_t v);
    return (v == CMIN) ? CMAX : -v;
  endfunction

  logic                    mode_q;
  comp_t                   key_q [4][4];
  logic [T_W-1:0]          t_q;
  logic signed [P_W-1:0]   mul_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [S_W-1:0]   s_q;
  logic signed [CF_W-1:0]  b_q, c_q, d_q;
  logic [S_W-1:0]          dq_q;
  logic [1:0]              rem_q;
  comp_t                   res_q [4];
  comp_t                   out_q [4];

  logic signed [CF_W-1:0]   e0, e1, e2, e3, a_c, b_c, c_c, d_c, hcoef;
  logic signed [S_W-1:0]    mul_a;
  comp_t                    mul_b, dot_a, dot_b;
  logic signed [P_W:0]      hsum;
  logic signed [S_W-1:0]    y_c, lres, rres;
  logic [3:0]               dv;
  logic [1:0]               qd;
  comp_t                    res_c;

  always_comb begin
    e0  = CF_W'(key_q[0][0]);
    e1  = CF_W'(key_q[1][0]);
    e2  = CF_W'(key_q[2][0]);
    e3  = CF_W'(key_q[3][0]);
    a_c = CF_W'(-e0 + 3 * e1 - 3 * e2 + e3);
    if (mode_q) begin
      b_c = CF_W'(3 * e0 - 6 * e1 + 3 * e2);
      c_c = CF_W'(-2 * e0 - 3 * e1 + 6 * e2 - e3);
      d_c = CF_W'(6 * e1);
    end else begin
      b_c = CF_W'(2 * e0 - 5 * e1 + 4 * e2 - e3);
      c_c = CF_W'(e2 - e0);
      d_c = CF_W'(2 * e1);
    end
    case (cmd_i.idx)
      2'd0:    begin dot_a = key_q[0][0]; dot_b = key_q[1][0]; end
      2'd1:    begin dot_a = key_q[1][0]; dot_b = key_q[2][0]; end
      default: begin dot_a = key_q[2][0]; dot_b = key_q[3][0]; end
    endcase
    if (cmd_i.op == OP_HMUL) begin
      mul_a = s_q;
      mul_b = comp_t'({1'b0, t_q});
    end else begin
      mul_a = S_W'(dot_a);
      mul_b = dot_b;
    end
    case (cmd_i.hstep)
      2'd0:    hcoef = b_q;
      2'd1:    hcoef = c_q;
      default: hcoef = d_q;
    endcase
    hsum = (P_W + 1)'(mul_q) + ((P_W + 1)'(hcoef) <<< 16)
         + ((cmd_i.hstep != 2'd2) ? (P_W + 1)'(32768)
            : (mode_q ? (P_W + 1)'(3 * 65536) : (P_W + 1)'(65536)));
    y_c  = S_W'(hsum >>> 16);
    dv   = {rem_q, dq_q[S_W-1 -: 2]};
    if (dv >= 4'd9) begin
      qd = 2'd3;
    end else if (dv >= 4'd6) begin
      qd = 2'd2;
    end else if (dv >= 4'd3) begin
      qd = 2'd1;
    end else begin
      qd = 2'd0;
    end
    lres = $signed(dq_q) - S_W'(DIV_OFFS);
    rres = mode_q ? (lres >>> 1) : (s_q >>> 1);
    if (rres > S_W'(CMAX)) begin
      res_c = CMAX;
    end else if (rres < S_W'(CMIN)) begin
      res_c = CMIN;
    end else begin
      res_c = comp_t'(rres);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 4; j++) begin
          key_q[k][j] <= '0;
        end
      end
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      case (cmd_i.op)
        OP_PUSH: begin
          for (int k = 0; k < 3; k++) begin
            key_q[k] <= key_q[k+1];
          end
          key_q[3][0] <= key_w_i;
          key_q[3][1] <= key_x_i;
          key_q[3][2] <= key_y_i;
          key_q[3][3] <= key_z_i;
        end
        OP_DMUL, OP_COEF: begin
          for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 4; j++) begin
              key_q[k][j] <= key_q[k][(j+1)%4];
            end
          end
        end
        OP_FLIP: begin
          if (acc_q < 0) begin
            for (int k = 1; k < 4; k++) begin
              if (2'(k - 1) == cmd_i.idx) begin
                for (int j = 0; j < 4; j++) begin
                  key_q[k][j] <= neg_sat(key_q[k][j]);
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: begin
        t_q   <= (interp_t_i > T_W'(T_ONE)) ? T_W'(T_ONE) : interp_t_i;
        mul_q <= '0;
        acc_q <= '0;
      end
      OP_DMUL, OP_HMUL: begin
        mul_q <= mul_a * mul_b;
        if (cmd_i.op == OP_DMUL) begin
          acc_q <= acc_q + ACC_W'(mul_q);
        end
      end
      OP_DACC: begin
        acc_q <= acc_q + ACC_W'(mul_q);
      end
      OP_FLIP: begin
        acc_q <= '0;
        mul_q <= '0;
      end
      OP_COEF: begin
        s_q <= S_W'(a_c);
        b_q <= b_c;
        c_q <= c_c;
        d_q <= d_c;
      end
      OP_HADD: begin
        s_q <= y_c;
        if (cmd_i.hstep == 2'd2) begin
          dq_q  <= S_W'(y_c) + S_W'(3 * DIV_OFFS);
          rem_q <= 2'd0;
        end
      end
      OP_DSTEP: begin
        dq_q  <= {dq_q[S_W-3:0], qd};
        rem_q <= 2'(dv - 4'(3 * qd));
      end
      OP_FIN: begin
        res_q[3] <= res_c;
        for (int k = 0; k < 3; k++) begin
          res_q[k] <= res_q[k+1];
        end
      end
      default: begin
      end
    endcase
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign out_w_o = out_q[0];
  assign out_x_o = out_q[1];
  assign out_y_o = out_q[2];
  assign out_z_o = out_q[3];

endmodule

// ----- test/tb_quaternion_spline_interpolator_top.sv -----
// Self-checking testbench for the quaternion spline interpolator top level.
// Drives push and evaluate items over qsi_in_if, checks results on qsi_out_if
// against a behavioral window/harmonize/Horner predictor. Depends on qsi_pkg.
module tb_quaternion_spline_interpolator_top;
  import qsi_pkg::*;

  localparam int HOLD_CYCLES  = 4000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  qsi_in_if  in_ch ();
  qsi_out_if out_ch ();

  quaternion_spline_interpolator_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source)
  );

  longint keys[16];
  logic   mode_q;
  quat_t  expected_quats[$];
  int     error_count;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     quiet_cycles;
  int     push_count;
  int     eval_count;
  int     result_count;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint sat_comp(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function automatic longint fdiv(longint x, longint d);
    longint q;
    q = x / d;
    if ((x % d) < 0) q--;
    return q;
  endfunction

  function automatic longint rdiv(longint x, longint d);
    return fdiv(x + d / 2, d);
  endfunction

  function automatic void flip_if_opposed(int prev, int nxt);
    longint dot;
    dot = 0;
    for (int c = 0; c < 4; c++) dot += keys[prev*4+c] * keys[nxt*4+c];
    if (dot < 0)
      for (int c = 0; c < 4; c++) keys[nxt*4+c] = sat_comp(-keys[nxt*4+c]);
  endfunction

  function automatic comp_t spline_comp(int comp, longint t);
    longint p0, p1, p2, p3, a, b, c, d, s, s1, s2;
    p0 = keys[comp];
    p1 = keys[4+comp];
    p2 = keys[8+comp];
    p3 = keys[12+comp];
    a = -p0 + 3*p1 - 3*p2 + p3;
    if (mode_q == 1'b0) begin
      s = 2;
      b = 2*p0 - 5*p1 + 4*p2 - p3;
      c = p2 - p0;
      d = 2*p1;
    end else begin
      s = 6;
      b = 3*p0 - 6*p1 + 3*p2;
      c = -2*p0 - 3*p1 + 6*p2 - p3;
      d = 6*p1;
    end
    s1 = rdiv(a*t + b*65536, 65536);
    s2 = rdiv(s1*t + c*65536, 65536);
    return comp_t'(sat_comp(rdiv(s2*t + d*65536, s*65536)));
  endfunction

  function automatic void predict_item(logic cmd, quat_t k, logic [T_W-1:0] t_raw);
    longint t;
    quat_t  q;
    if (cmd == 1'b0) begin
      for (int i = 0; i < 12; i++) keys[i] = keys[i+4];
      keys[12] = k.w;
      keys[13] = k.x;
      keys[14] = k.y;
      keys[15] = k.z;
      push_count++;
    end else begin
      t = (t_raw > T_ONE) ? T_ONE : t_raw;
      flip_if_opposed(0, 1);
      flip_if_opposed(1, 2);
      flip_if_opposed(2, 3);
      q.w = spline_comp(0, t);
      q.x = spline_comp(1, t);
      q.y = spline_comp(2, t);
      q.z = spline_comp(3, t);
      expected_quats.push_back(q);
      eval_count++;
    end
  endfunction

  task automatic report_mismatch(string what, comp_t got, comp_t want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  task automatic send_item(logic cmd, quat_t k, logic [T_W-1:0] t_raw);
    while (($urandom % 100) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= cmd;
    in_ch.key_w    <= k.w;
    in_ch.key_x    <= k.x;
    in_ch.key_y    <= k.y;
    in_ch.key_z    <= k.z;
    in_ch.interp_t <= t_raw;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_item(cmd, k, t_raw);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_quats.size() == 0) begin
          $display("MISMATCH unexpected result");
          error_count++;
        end else begin
          quat_t q;
          q = expected_quats.pop_front();
          if (out_ch.out_w !== q.w) report_mismatch("w", out_ch.out_w, q.w);
          if (out_ch.out_x !== q.x) report_mismatch("x", out_ch.out_x, q.x);
          if (out_ch.out_y !== q.y) report_mismatch("y", out_ch.out_y, q.y);
          if (out_ch.out_z !== q.z) report_mismatch("z", out_ch.out_z, q.z);
          result_count++;
        end
      end
      out_ch.ready <= (($urandom % 100) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HOLD_CYCLES) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0: return comp_t'(-131072);
      1: return comp_t'(131071);
      2: return comp_t'(int'($urandom_range(0, 2000)) - 1000);
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic quat_t rand_key();
    quat_t k;
    k.w = rand_comp();
    k.x = rand_comp();
    k.y = rand_comp();
    k.z = rand_comp();
    return k;
  endfunction

  function automatic logic [T_W-1:0] rand_t();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return T_W'(T_ONE);
      2: return T_W'($urandom_range(T_ONE + 1, 131071));
      default: return T_W'($urandom_range(0, T_ONE));
    endcase
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mode_q = m;
  endtask

  task automatic push_key(comp_t w, comp_t x, comp_t y, comp_t z);
    quat_t k;
    k = '{w: w, x: x, y: y, z: z};
    send_item(1'b0, k, '0);
  endtask

  task automatic eval_at(logic [T_W-1:0] t_raw);
    send_item(1'b1, rand_key(), t_raw);
  endtask

  task automatic test_reset_window();
    eval_at(T_ONE / 2);
    push_key(16'sd1000, 0, 0, 0);
    eval_at(T_ONE);
  endtask

  task automatic test_extremes(logic m);
    write_mode(m);
    push_key(-131072, -131072, 131071, 0);
    push_key(131071, 131071, -131072, -131072);
    push_key(-131072, 131071, -131072, 131071);
    push_key(131071, -131072, 131071, -131072);
    eval_at(0);
    eval_at(T_ONE);
    eval_at(131071);
    push_key(32768, 0, 0, 0);
    push_key(0, 32768, 0, 0);
    eval_at(T_ONE / 3);
    push_key(-32768, 0, 0, 0);
    eval_at(12345);
  endtask

  task automatic test_random(int n, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        for (int j = 0; j < 4; j++) send_item(1'b0, rand_key(), rand_t());
        for (int j = 0; j < 3; j++) eval_at(rand_t());
        i += 6;
      end else begin
        send_item(logic'($urandom_range(0, 1)), rand_key(), rand_t());
      end
    end
  endtask

  initial begin
    error_count    = 0;
    push_count     = 0;
    eval_count     = 0;
    result_count   = 0;
    mode_q         = 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    quiet_cycles   = 0;
    for (int i = 0; i < 16; i++) keys[i] = 0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = 1'b0;
    in_ch.key_w    = '0;
    in_ch.key_x    = '0;
    in_ch.key_y    = '0;
    in_ch.key_z    = '0;
    in_ch.interp_t = '0;
    out_ch.ready   = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_window();
    test_extremes(1'b1);
    test_extremes(1'b0);
    write_mode(1'b1);
    test_random(200, 6, 84);
    write_mode(1'b0);
    test_random(230, 84, 6);
    write_mode(1'b1);
    test_random(420, 0, 0);
    write_mode(1'b0);
    test_random(420, 0, 0);
    wait_drained();

    $display("Covered %0d pushes and %0d evaluates, %0d results checked, both modes.",
             push_count, eval_count, result_count);
    if (error_count == 0 && expected_quats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
design/qsi_pkg.sv
design/qsi_in_if.sv
design/qsi_out_if.sv
design/qsi_ctrl.sv
design/qsi_dp.sv
design/quaternion_spline_interpolator_top.sv
test/tb_quaternion_spline_interpolator_top.sv
